>>> rtl/crcdf_pkg.sv
`timescale 1ns / 1ps

package crcdf_pkg;

    localparam logic [15:0] CRC_SEED = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [7:0]  MAX_LEN_RESET = 8'hFF;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_SIZE     = 2'd1,
        STATUS_CRC      = 2'd2
    } status_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_VERDICT = 1'b1
    } kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } in_beat_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        status_t     status;
        logic [7:0]  message_id;
        logic [7:0]  sequence_res;
        logic [7:0]  payload_length;
        logic [15:0] frame_crc;
        logic        last;
    } out_beat_t;

    // One byte through CRC-16-CCITT, MSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] crc;
        crc = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (crc[15])
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            else
                crc = {crc[14:0], 1'b0};
        end
        return crc;
    endfunction

endpackage

>>> rtl/crc16_frame_deframer.sv
`timescale 1ns / 1ps

// Byte-serial deframer for frames of id, sequence, length, payload and a
// CRC-16-CCITT (init 0xFFFF, poly 0x1021, MSB first, sent low byte first).
// One byte is accepted per clock while in_stall is low; the rate is set by the
// combinational byte-wide CRC update between the input port and the state and
// result registers. Each payload byte comes out with its index, then one verdict
// beat (ok, invalid size or crc mismatch) with last set. Bytes after a verdict
// are dropped up to the buffer end flag. Results pass through an output register
// backed by a one-entry skid register, so a stalled result does not hold up input
// until a second result is waiting. max_len_reg resets to 255; the user must write
// it through the cfg channel only while idle; the block does not enforce this.
module crc16_frame_deframer
    import crcdf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_beat_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [7:0] cfg_data
);

    typedef enum logic [2:0] {
        PH_ID,
        PH_SEQ,
        PH_LEN,
        PH_PAYLOAD,
        PH_CRC_LO,
        PH_CRC_HI,
        PH_DROP
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  max_len_reg;
    logic [7:0]  id_reg, id_next;
    logic [7:0]  seq_reg, seq_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;

    logic        out_valid_reg;
    out_beat_t   out_reg;
    logic        skid_valid_reg;
    out_beat_t   skid_reg;

    logic        accept;
    logic        res_valid;
    out_beat_t   res;
    logic [15:0] crc_upd;
    logic [15:0] rx_crc;
    logic [7:0]  b;
    logic        end_flag;

    assign in_stall  = skid_valid_reg;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

    assign b        = in_data.data_byte;
    assign end_flag = in_data.buffer_end;
    assign crc_upd  = crc_byte((phase_reg == PH_ID) ? CRC_SEED : crc_reg, b);
    assign rx_crc   = {b, crc_lo_reg};

    always_comb
    begin
        phase_next  = phase_reg;
        id_next     = id_reg;
        seq_next    = seq_reg;
        len_next    = len_reg;
        count_next  = count_reg;
        crc_next    = crc_reg;
        crc_lo_next = crc_lo_reg;
        res_valid   = 1'b0;

        // Verdict template from the held header; fields are overridden per phase.
        res                = '0;
        res.kind           = KIND_VERDICT;
        res.status         = STATUS_SIZE;
        res.message_id     = id_reg;
        res.sequence_res   = seq_reg;
        res.payload_length = len_reg;
        res.last           = 1'b1;

        if (accept)
        begin
            unique case (phase_reg)
                PH_ID:
                begin
                    id_next     = b;
                    seq_next    = '0;
                    len_next    = '0;
                    count_next  = '0;
                    crc_lo_next = '0;
                    crc_next    = crc_upd;
                    res.message_id     = b;
                    res.sequence_res   = '0;
                    res.payload_length = '0;
                    res_valid   = end_flag;
                    phase_next  = end_flag ? PH_ID : PH_SEQ;
                end
                PH_SEQ:
                begin
                    seq_next  = b;
                    crc_next  = crc_upd;
                    res.sequence_res = b;
                    res_valid  = end_flag;
                    phase_next = end_flag ? PH_ID : PH_LEN;
                end
                PH_LEN:
                begin
                    len_next = b;
                    crc_next = crc_upd;
                    res.payload_length = b;
                    if (b > max_len_reg || end_flag)
                    begin
                        res_valid  = 1'b1;
                        phase_next = end_flag ? PH_ID : PH_DROP;
                    end
                    else
                    begin
                        count_next = '0;
                        phase_next = (b == 8'd0) ? PH_CRC_LO : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    res_valid = 1'b1;
                    if (end_flag)
                    begin
                        phase_next = PH_ID;
                    end
                    else
                    begin
                        crc_next          = crc_upd;
                        res               = '0;
                        res.kind          = KIND_PAYLOAD;
                        res.status        = STATUS_OK;
                        res.payload_byte  = b;
                        res.payload_index = count_reg;
                        count_next        = count_reg + 8'd1;
                        if (count_next >= len_reg)
                            phase_next = PH_CRC_LO;
                    end
                end
                PH_CRC_LO:
                begin
                    crc_lo_next = b;
                    res_valid   = end_flag;
                    phase_next  = end_flag ? PH_ID : PH_CRC_HI;
                end
                PH_CRC_HI:
                begin
                    res_valid     = 1'b1;
                    res.frame_crc = rx_crc;
                    res.status    = (rx_crc == crc_reg) ? STATUS_OK : STATUS_CRC;
                    phase_next    = end_flag ? PH_ID : PH_DROP;
                end
                PH_DROP:
                begin
                    if (end_flag)
                        phase_next = PH_ID;
                end
                default: phase_next = PH_ID;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_ID;
            max_len_reg    <= MAX_LEN_RESET;
            id_reg         <= '0;
            seq_reg        <= '0;
            len_reg        <= '0;
            count_reg      <= '0;
            crc_reg        <= CRC_SEED;
            crc_lo_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
            skid_valid_reg <= 1'b0;
            skid_reg       <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                max_len_reg <= cfg_data;

            phase_reg  <= phase_next;
            id_reg     <= id_next;
            seq_reg    <= seq_next;
            len_reg    <= len_next;
            count_reg  <= count_next;
            crc_reg    <= crc_next;
            crc_lo_reg <= crc_lo_next;

            // Output register drains first; skid only fills when it is held.
            if (!out_valid_reg || !out_stall)
            begin
                if (skid_valid_reg)
                begin
                    out_reg        <= skid_reg;
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_reg       <= res;
                    out_valid_reg <= res_valid;
                end
            end
            else if (res_valid)
            begin
                skid_reg       <= res;
                skid_valid_reg <= 1'b1;
            end
        end
    end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import crcdf_pkg::*;

    typedef enum logic [2:0] {
        AWAIT_ID,
        AWAIT_SEQ,
        AWAIT_LEN,
        IN_PAYLOAD,
        AWAIT_CRC_LO,
        AWAIT_CRC_HI,
        SKIP_TO_END
    } frame_phase_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    in_beat_t   in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_beat_t  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = 8'h00;

    in_beat_t  pending_bytes[$];
    out_beat_t expected_beats[$];
    int        bytes_queued = 0;
    int        error_count = 0;
    int        send_idle_pct = 0;
    int        stall_pct = 0;

    // deframer state as predicted
    frame_phase_t frame_phase = AWAIT_ID;
    logic [7:0]   max_len = MAX_LEN_RESET;
    logic [7:0]   held_id = 8'h00;
    logic [7:0]   held_seq = 8'h00;
    logic [7:0]   held_len = 8'h00;
    logic [7:0]   pay_count = 8'h00;
    logic [7:0]   crc_lo_byte = 8'h00;
    logic [15:0]  crc_acc = CRC_SEED;

    crc16_frame_deframer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // bitwise LFSR form: feedback is the top CRC bit xor the next data bit
    function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--)
        begin
            fb  = acc[15] ^ b[i];
            acc = {acc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return acc;
    endfunction

    task automatic push_verdict(input status_t st, input logic [15:0] rx_crc, input bit at_end);
        out_beat_t v;
        v                = '0;
        v.kind           = KIND_VERDICT;
        v.status         = st;
        v.message_id     = held_id;
        v.sequence_res   = held_seq;
        v.payload_length = held_len;
        v.frame_crc      = rx_crc;
        v.last           = 1'b1;
        expected_beats.push_back(v);
        frame_phase = at_end ? AWAIT_ID : SKIP_TO_END;
    endtask

    task automatic deframe_byte(input in_beat_t beat);
        out_beat_t   p;
        logic [7:0]  b;
        logic [15:0] rx_crc;
        b = beat.data_byte;
        case (frame_phase)
            AWAIT_ID:
            begin
                held_id     = b;
                held_seq    = 8'h00;
                held_len    = 8'h00;
                pay_count   = 8'h00;
                crc_lo_byte = 8'h00;
                crc_acc     = crc_step(CRC_SEED, b);
                if (beat.buffer_end)
                    push_verdict(STATUS_SIZE, 16'h0000, 1'b1);
                else
                    frame_phase = AWAIT_SEQ;
            end
            AWAIT_SEQ:
            begin
                held_seq = b;
                crc_acc  = crc_step(crc_acc, b);
                if (beat.buffer_end)
                    push_verdict(STATUS_SIZE, 16'h0000, 1'b1);
                else
                    frame_phase = AWAIT_LEN;
            end
            AWAIT_LEN:
            begin
                held_len = b;
                crc_acc  = crc_step(crc_acc, b);
                if (b > max_len || beat.buffer_end)
                    push_verdict(STATUS_SIZE, 16'h0000, beat.buffer_end);
                else
                begin
                    pay_count   = 8'h00;
                    frame_phase = (b == 8'h00) ? AWAIT_CRC_LO : IN_PAYLOAD;
                end
            end
            IN_PAYLOAD:
            begin
                // end flag on a payload byte replaces it with the verdict
                if (beat.buffer_end)
                    push_verdict(STATUS_SIZE, 16'h0000, 1'b1);
                else
                begin
                    crc_acc         = crc_step(crc_acc, b);
                    p               = '0;
                    p.kind          = KIND_PAYLOAD;
                    p.payload_byte  = b;
                    p.payload_index = pay_count;
                    expected_beats.push_back(p);
                    pay_count = pay_count + 8'd1;
                    if (pay_count >= held_len)
                        frame_phase = AWAIT_CRC_LO;
                end
            end
            AWAIT_CRC_LO:
            begin
                crc_lo_byte = b;
                if (beat.buffer_end)
                    push_verdict(STATUS_SIZE, 16'h0000, 1'b1);
                else
                    frame_phase = AWAIT_CRC_HI;
            end
            AWAIT_CRC_HI:
            begin
                rx_crc = {b, crc_lo_byte};
                push_verdict((rx_crc == crc_acc) ? STATUS_OK : STATUS_CRC, rx_crc,
                             beat.buffer_end);
            end
            default:
            begin
                if (beat.buffer_end)
                    frame_phase = AWAIT_ID;
            end
        endcase
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            error_count++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endfunction

    task automatic compare_beat(input out_beat_t want, input out_beat_t got);
        check_field("kind", want.kind, got.kind);
        check_field("payload_byte", want.payload_byte, got.payload_byte);
        check_field("payload_index", want.payload_index, got.payload_index);
        check_field("status", want.status, got.status);
        check_field("message_id", want.message_id, got.message_id);
        check_field("sequence_res", want.sequence_res, got.sequence_res);
        check_field("payload_length", want.payload_length, got.payload_length);
        check_field("frame_crc", want.frame_crc, got.frame_crc);
        check_field("last", want.last, got.last);
    endtask

    // driver: a held beat stays put until accepted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                deframe_byte(in_data);
            if (!in_valid || !in_stall)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_bytes.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_beats.size() == 0)
                begin
                    error_count++;
                    $error("unexpected result beat: kind %0d status %0d",
                           out_data.kind, out_data.status);
                end
                else
                    compare_beat(expected_beats.pop_front(), out_data);
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic queue_byte(input logic [7:0] d, input logic e);
        in_beat_t beat;
        beat.data_byte  = d;
        beat.buffer_end = e;
        pending_bytes.push_back(beat);
        bytes_queued++;
    endtask

    // cut >= 0 puts the end flag on that byte index when it falls short of
    // the full frame; otherwise trail extra bytes follow the CRC
    task automatic queue_frame(input logic [7:0] id, input logic [7:0] seq,
                               input logic [7:0] len, input int cut, input int trail,
                               input bit bad_crc);
        logic [7:0]  bytes[$];
        logic [15:0] crc;
        int          n;
        bytes.push_back(id);
        bytes.push_back(seq);
        bytes.push_back(len);
        for (int i = 0; i < len; i++)
            bytes.push_back(8'($urandom));
        crc = CRC_SEED;
        foreach (bytes[i])
            crc = crc_step(crc, bytes[i]);
        if (bad_crc)
            crc = crc ^ 16'($urandom_range(1, 65535));
        bytes.push_back(crc[7:0]);
        bytes.push_back(crc[15:8]);
        if (cut >= 0 && cut < bytes.size() - 1)
            n = cut + 1;
        else
        begin
            repeat (trail) bytes.push_back(8'($urandom));
            n = bytes.size();
        end
        for (int i = 0; i < n; i++)
            queue_byte(bytes[i], i == n - 1);
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || in_valid || expected_beats.size() != 0)
            @(posedge clk);
        // dropped bytes make no result but may still be in flight
        repeat (8) @(posedge clk);
    endtask

    task automatic set_max_len(input logic [7:0] v);
        wait_drained();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        max_len = v;
    endtask

    task automatic random_traffic(input int n_bytes);
        int         start;
        int         pick;
        int         len;
        int         trail;
        int         cap;
        logic [7:0] m;
        start = bytes_queued;
        while (bytes_queued - start < n_bytes)
        begin
            m     = max_len;
            cap   = (m < 12) ? m : 12;
            len   = ($urandom_range(0, 19) == 0) ? $urandom_range(0, (m < 40) ? m : 40)
                                                 : $urandom_range(0, cap);
            trail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            pick  = $urandom_range(0, 99);
            if (pick < 62 || (pick >= 72 && pick < 80 && m == 8'hFF))
                queue_frame(8'($urandom), 8'($urandom), 8'(len), -1, trail, 1'b0);
            else if (pick < 72)
                queue_frame(8'($urandom), 8'($urandom), 8'(len), -1, trail, 1'b1);
            else if (pick < 80)
                queue_frame(8'($urandom), 8'($urandom), 8'($urandom_range(m + 1, 255)),
                            $urandom_range(2, 5), 0, 1'b0);
            else if (pick < 90)
                queue_frame(8'($urandom), 8'($urandom), 8'(len),
                            $urandom_range(0, len + 3), 0, 1'b0);
            else
            begin
                pick = $urandom_range(1, 6);
                for (int i = 0; i < pick; i++)
                    queue_byte(8'($urandom), i == pick - 1);
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 33;
        stall_pct     = 80;

        // directed, reset maximum of 255
        queue_frame(8'hFF, 8'h00, 8'd0, -1, 0, 1'b0);   // zero length
        queue_frame(8'h00, 8'hFF, 8'd2, -1, 1, 1'b0);   // trailing byte dropped
        queue_frame(8'h5A, 8'hA5, 8'd0, -1, 0, 1'b1);   // crc mismatch
        queue_frame(8'h11, 8'h22, 8'd3, 0, 0, 1'b0);    // ends on id
        queue_frame(8'h33, 8'h44, 8'd3, 1, 0, 1'b0);    // ends on sequence
        queue_frame(8'h55, 8'h66, 8'd3, 2, 0, 1'b0);    // ends on length
        queue_frame(8'h77, 8'h88, 8'd2, 4, 0, 1'b0);    // ends inside payload
        queue_frame(8'h99, 8'hAA, 8'd0, 3, 0, 1'b0);    // ends on crc low byte

        // register changes between header bytes; length checked on arrival
        queue_byte(8'hC3, 1'b0);
        queue_byte(8'h3C, 1'b0);
        set_max_len(8'd0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b1);

        random_traffic(300);

        set_max_len(8'hFF);
        queue_frame(8'($urandom), 8'($urandom), 8'd255, -1, 0, 1'b0);
        random_traffic(300);

        send_idle_pct = 80;
        stall_pct     = 33;
        set_max_len(8'($urandom_range(1, 254)));
        random_traffic(400);
        set_max_len(8'd16);
        random_traffic(400);

        send_idle_pct = 0;
        stall_pct     = 0;
        set_max_len(8'd1);
        random_traffic(300);

        wait_drained();
        if (error_count == 0 && expected_beats.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule

>>> files.f
rtl/crcdf_pkg.sv
rtl/crc16_frame_deframer.sv
tb/sv/testbench.sv
